FILE: design/fdl_pkg.sv
`default_nettype none
package fdl_pkg;

  localparam int unsigned DEPTH_DEF = 131072;
  localparam int unsigned SAMPLE_BITS_DEF = 24;

  localparam int unsigned RATE_W = 17;
  localparam int unsigned MS_W = 11;
  localparam int unsigned FB_W = 15;
  localparam int unsigned MIX_W = 16;
  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;

  localparam logic [RATE_W-1:0] RATE_RST = 17'd48000;
  localparam logic [MS_W-1:0] MS_RST = 11'd500;
  localparam logic [FB_W-1:0] FB_RST = 15'd13107;
  localparam logic [MIX_W-1:0] MIX_RST = 16'd16384;

  // divider sized for rate*ms in Q.16
  localparam int unsigned DIV_NUM_W = RATE_W + MS_W + 16;
  localparam int unsigned DIV_DEN_W = 12;
  localparam int unsigned MS_PER_S = 1000;
  localparam int unsigned RAMP_DIV = 20;
  localparam int unsigned RAMP_MAX = 4095;
  localparam int unsigned MIX_ONE = 32768;
  localparam int unsigned RND_HALF = 16384;

  typedef enum logic [1:0] {
    REG_RATE = 2'd0,
    REG_MS   = 2'd1,
    REG_FB   = 2'd2,
    REG_MIX  = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage
`default_nettype wire

FILE: design/fdl_div.sv
`default_nettype none
module fdl_div #(
  parameter int unsigned NUM_W = fdl_pkg::DIV_NUM_W,
  parameter int unsigned DEN_W = fdl_pkg::DIV_DEN_W
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [NUM_W-1:0]    num,
  input  logic [DEN_W-1:0]    den,
  output logic [NUM_W-1:0]    quo,
  output fdl_pkg::div_stat_t  stat
);
  import fdl_pkg::*;

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_W - 1);

  logic [NUM_W-1:0] num_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   rem_sub;
  logic             qbit;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    rem_sh  = {rem_r, num_r[NUM_W-1]};
    qbit    = (rem_sh >= {1'b0, den_r});
    rem_sub = rem_sh - {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        num_r  <= num;
        den_r  <= den;
        rem_r  <= '0;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        num_r <= {num_r[NUM_W-2:0], qbit};
        rem_r <= qbit ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign quo       = num_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule
`default_nettype wire

FILE: design/feedback_delay_line.sv
// ---------------------------------------------------------------------------
// channel   direction  handshake            payload
// in        sink       in_valid/in_ready    in_sample_in   (signed)
// out       source     out_valid/out_ready  out_sample_out (signed)
// cfg       APB slave  psel/penable/pready  paddr, pwdata, prdata
//
// A request walks the target, ramp, read, interpolate, mix, feedback, write
// and done states before in_ready returns; the target delay and ramp length
// come from reciprocal multiplies. A request that moves the target and
// starts a ramp also waits on the bit-serial divider forming the ramp step.
// in_ready is high only while the sequencer is idle.
// Reset is synchronous; the delay memory needs no clearing pass: a wrap flag
// plus the write pointer mark never-written cells, which read as zero.
// A result held in the output register stalls only the final load, never
// the config port.
// ---------------------------------------------------------------------------
`default_nettype none
module feedback_delay_line #(
  parameter int unsigned DELAY_DEPTH = fdl_pkg::DEPTH_DEF,
  parameter int unsigned SAMPLE_BITS = fdl_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_sample_out,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fdl_pkg::ADDR_W-1:0]    paddr,
  input  logic [fdl_pkg::DATA_W-1:0]    pwdata,
  output logic [fdl_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);
  import fdl_pkg::*;

  localparam int unsigned SB    = SAMPLE_BITS;
  localparam int unsigned AW    = $clog2(DELAY_DEPTH);
  localparam int unsigned DLY_W = AW + 16;
  localparam int unsigned RP_W  = AW + 17;
  localparam int unsigned A_W   = (SB + 2 > RATE_W + 1) ? SB + 2 : RATE_W + 1;
  localparam int unsigned B_W   = 17;
  localparam int unsigned P_W   = A_W + B_W;
  localparam int unsigned ACC_W = P_W + 1;

  // Q.16 over 1000 reduces to 8192 over 125; both quotients by 125 and the
  // ramp length by 20 use rounded-up reciprocals that are exact over the range
  localparam int unsigned PRD_W   = RATE_W + MS_W;
  localparam int unsigned TGT_DEN = MS_PER_S / 8;
  localparam int unsigned TQ_SH   = PRD_W + 7;
  localparam int unsigned TQ_W    = PRD_W - 6;
  localparam int unsigned QP_W    = 2 * PRD_W + 1;
  localparam int unsigned TR_W    = (DLY_W > TQ_W + 13) ? DLY_W : TQ_W + 13;
  localparam int unsigned SP_W    = RATE_W + 18;
  localparam logic [PRD_W:0] RCP_TGT =
    (PRD_W + 1)'(((64'd1 << TQ_SH) + 64'(TGT_DEN) - 64'd1) / 64'(TGT_DEN));
  localparam logic [20:0] RCP_FRC =
    21'(((64'd1 << 27) + 64'(TGT_DEN) - 64'd1) / 64'(TGT_DEN));
  localparam logic [17:0] RCP_STP =
    18'(((64'd1 << 22) + 64'(RAMP_DIV) - 64'd1) / 64'(RAMP_DIV));

  localparam logic [DLY_W-1:0] LIMIT = DLY_W'(DELAY_DEPTH - 1) << 16;
  localparam logic [RP_W-1:0]  SPAN  = RP_W'(DELAY_DEPTH) << 16;
  localparam logic [AW-1:0]    LAST  = AW'(DELAY_DEPTH - 1);
  localparam logic [AW:0]      DEPTH_X = (AW + 1)'(DELAY_DEPTH);
  localparam logic signed [ACC_W-1:0] SAT_HI =
    ACC_W'((longint'(1) <<< (SB - 1)) - longint'(1));
  localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-(longint'(1) <<< (SB - 1)));
  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(RND_HALF);
  localparam logic [16:0] MIX_ONE_C = 17'(MIX_ONE);

  typedef enum logic [4:0] {
    S_IDLE, S_MUL_TGT, S_TGT_Q, S_TGT_R, S_TGT_F, S_RAMP,
    S_RMP_GO, S_RMP_WAIT, S_ADV, S_ADDR, S_RD1, S_RD2, S_INTERP, S_DLY,
    S_DRY, S_WET, S_FB, S_WR, S_DONE
  } state_t;

  function automatic logic signed [SB-1:0] sat_f(input logic signed [ACC_W-1:0] v);
    if (v > SAT_HI) begin
      return SAT_HI[SB-1:0];
    end else if (v < SAT_LO) begin
      return SAT_LO[SB-1:0];
    end
    return v[SB-1:0];
  endfunction

  // config registers
  logic [RATE_W-1:0] rate_r;
  logic [MS_W-1:0]   ms_r;
  logic [FB_W-1:0]   fb_r;
  logic [MIX_W-1:0]  mix_r;

  // sequencer and delay state
  state_t                  state_r;
  logic [AW-1:0]           wp_r;
  logic                    wrapped_r;
  logic [DLY_W-1:0]        cur_r;
  logic signed [DLY_W:0]   step_r;
  logic [11:0]             left_r;
  logic [DLY_W-1:0]        rtgt_r;
  logic [DLY_W-1:0]        tgt_r;
  logic [11:0]             steps_r;

  // target formation
  logic [PRD_W-1:0]        tgt_a_r;
  logic [TQ_W-1:0]         tgt_q_r;
  logic [6:0]              tgt_rem_r;
  logic [QP_W-1:0]         q_prod;
  logic [SP_W-1:0]         stp_prod;
  logic [12:0]             steps_raw;
  logic [PRD_W-1:0]        rem_full;
  logic [27:0]             frc_prod;
  logic [TR_W-1:0]         tgt_raw;

  // datapath
  logic signed [SB-1:0]    x_r;
  logic signed [P_W-1:0]   prod_r;
  logic signed [ACC_W-1:0] acc_r;
  logic [AW-1:0]           i1_r;
  logic [AW-1:0]           i2_r;
  logic [15:0]             frac_r;
  logic signed [SB-1:0]    m1_r;
  logic signed [SB-1:0]    dly_r;
  logic signed [SB-1:0]    out_r;
  logic                    out_valid_r;

  // memory
  logic signed [SB-1:0]    mem [DELAY_DEPTH];
  logic signed [SB-1:0]    rd_r;
  logic                    rdv_r;
  logic [AW-1:0]           raddr;
  logic                    mem_we;
  logic signed [SB-1:0]    wdata;

  // divider
  logic                    div_start;
  logic [DIV_NUM_W-1:0]    div_num;
  logic [DIV_DEN_W-1:0]    div_den;
  logic [DIV_NUM_W-1:0]    div_quo;
  div_stat_t               div_stat;

  // shared multiplier
  logic signed [A_W-1:0]   mul_a;
  logic signed [B_W-1:0]   mul_b;

  // misc combinational
  logic                    cfg_wr;
  logic [16:0]             mixc;
  logic                    tgt_neg;
  logic [DLY_W-1:0]        tgt_mag;
  logic signed [SB-1:0]    m_rd;
  logic signed [SB:0]      m_dif;
  logic signed [DLY_W+1:0] cur_sum;
  logic [RP_W-1:0]         wpq;
  logic [RP_W-1:0]         rp;
  logic [AW:0]             i1_full;
  logic [AW-1:0]           i1;
  logic signed [ACC_W-1:0] fb_rnd;
  logic signed [ACC_W-1:0] w_acc;
  logic signed [ACC_W-1:0] y_rnd;

  fdl_div #(
    .NUM_W (DIV_NUM_W),
    .DEN_W (DIV_DEN_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .quo   (div_quo),
    .stat  (div_stat)
  );

  assign cfg_wr = psel & penable & pwrite;
  assign pready = 1'b1;

  always_comb begin
    unique case (reg_idx_t'(paddr[3:2]))
      REG_RATE: prdata = DATA_W'(rate_r);
      REG_MS:   prdata = DATA_W'(ms_r);
      REG_FB:   prdata = DATA_W'(fb_r);
      REG_MIX:  prdata = DATA_W'(mix_r);
      default:  prdata = '0;
    endcase
  end

  assign mixc    = (mix_r > MIX_W'(MIX_ONE)) ? MIX_ONE_C : {1'b0, mix_r};
  assign tgt_neg = (tgt_r < cur_r);
  assign tgt_mag = tgt_neg ? (cur_r - tgt_r) : (tgt_r - cur_r);
  assign m_rd    = rdv_r ? rd_r : '0;
  assign m_dif   = (SB + 1)'(m_rd) - (SB + 1)'(m1_r);
  assign cur_sum = (DLY_W + 2)'($signed({1'b0, cur_r})) + (DLY_W + 2)'(step_r);

  // target = rate*ms*8192/125: whole part by reciprocal, then the remainder's share
  always_comb begin
    q_prod    = QP_W'(prod_r[PRD_W-1:0]) * QP_W'(RCP_TGT);
    stp_prod  = SP_W'(rate_r) * SP_W'(RCP_STP);
    steps_raw = stp_prod[SP_W-1:22];
    rem_full  = tgt_a_r - PRD_W'(tgt_q_r) * PRD_W'(TGT_DEN);
    frc_prod  = 28'(tgt_rem_r) * 28'(RCP_FRC);
    tgt_raw   = TR_W'({tgt_q_r, 13'h0}) + TR_W'(frc_prod[27:14]);
  end

  // read position: write pointer minus delay, wrapped into the memory span
  always_comb begin
    wpq     = RP_W'({wp_r, 16'h0});
    rp      = (wpq < RP_W'(cur_r)) ? (wpq + SPAN - RP_W'(cur_r)) : (wpq - RP_W'(cur_r));
    i1_full = rp[RP_W-1:16];
    i1      = (i1_full >= DEPTH_X) ? '0 : i1_full[AW-1:0];
  end

  // feedback writeback and output mix, both rounded half up and saturated
  always_comb begin
    fb_rnd = (ACC_W'(prod_r) + HALF) >>> 15;
    w_acc  = ACC_W'(x_r) + fb_rnd;
    y_rnd  = (acc_r + HALF) >>> 15;
    wdata  = sat_f(w_acc);
  end

  // divider operand select: ramp step only
  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    unique case (state_r)
      S_RMP_GO: begin
        div_start = ~div_stat.busy;
        div_num   = DIV_NUM_W'(tgt_mag);
        div_den   = steps_r;
      end
      default: begin
      end
    endcase
  end

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_MUL_TGT: begin
        mul_a = A_W'($signed({1'b0, rate_r}));
        mul_b = B_W'($signed({1'b0, ms_r}));
      end
      S_INTERP: begin
        mul_a = A_W'(m_dif);
        mul_b = $signed({1'b0, frac_r});
      end
      S_DRY: begin
        mul_a = A_W'(x_r);
        mul_b = $signed(MIX_ONE_C - mixc);
      end
      S_WET: begin
        mul_a = A_W'(dly_r);
        mul_b = $signed(mixc);
      end
      S_FB: begin
        mul_a = A_W'(dly_r);
        mul_b = $signed({2'b0, fb_r});
      end
      default: begin
      end
    endcase
  end

  // delay memory: one read port, one write port, registered read with its valid mark
  assign raddr  = (state_r == S_RD1) ? i1_r : i2_r;
  assign mem_we = (state_r == S_WR);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wp_r] <= wdata;
    end
    rd_r  <= mem[raddr];
    rdv_r <= wrapped_r | (raddr < wp_r);
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wp_r        <= '0;
      wrapped_r   <= 1'b0;
      cur_r       <= '0;
      step_r      <= '0;
      left_r      <= '0;
      rtgt_r      <= '0;
      out_valid_r <= 1'b0;
      rate_r      <= RATE_RST;
      ms_r        <= MS_RST;
      fb_r        <= FB_RST;
      mix_r       <= MIX_RST;
    end else begin
      prod_r <= mul_a * mul_b;

      if (cfg_wr) begin
        unique case (reg_idx_t'(paddr[3:2]))
          REG_RATE: rate_r <= pwdata[RATE_W-1:0];
          REG_MS:   ms_r   <= pwdata[MS_W-1:0];
          REG_FB:   fb_r   <= pwdata[FB_W-1:0];
          REG_MIX:  mix_r  <= pwdata[MIX_W-1:0];
          default: begin
          end
        endcase
      end

      // drop the taken result; the done state sets valid again by itself
      if (out_valid_r && out_ready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            x_r     <= in_sample_in;
            state_r <= S_MUL_TGT;
          end
        end
        S_MUL_TGT: state_r <= S_TGT_Q;
        S_TGT_Q: begin
          // hold rate*ms, form its quotient by 125 and the clamped ramp length
          tgt_a_r <= prod_r[PRD_W-1:0];
          tgt_q_r <= q_prod[QP_W-1:TQ_SH];
          steps_r <= (steps_raw > 13'(RAMP_MAX)) ? 12'(RAMP_MAX) : steps_raw[11:0];
          state_r <= S_TGT_R;
        end
        S_TGT_R: begin
          tgt_rem_r <= rem_full[6:0];
          state_r   <= S_TGT_F;
        end
        S_TGT_F: begin
          // clamp the target to the last cell of the memory
          tgt_r   <= (tgt_raw > TR_W'(LIMIT)) ? LIMIT : tgt_raw[DLY_W-1:0];
          state_r <= S_RAMP;
        end
        S_RAMP: begin
          // restart the ramp only when the target moves
          if (tgt_r != rtgt_r) begin
            rtgt_r <= tgt_r;
            if (steps_r == '0) begin
              cur_r   <= tgt_r;
              left_r  <= '0;
              step_r  <= '0;
              state_r <= S_ADV;
            end else begin
              left_r  <= steps_r;
              state_r <= S_RMP_GO;
            end
          end else begin
            state_r <= S_ADV;
          end
        end
        S_RMP_GO: begin
          if (!div_stat.busy) begin
            state_r <= S_RMP_WAIT;
          end
        end
        S_RMP_WAIT: begin
          // step truncates toward zero: divide the magnitude, then restore the sign
          if (div_stat.done) begin
            step_r  <= tgt_neg ? -$signed(div_quo[DLY_W:0]) : $signed(div_quo[DLY_W:0]);
            state_r <= S_ADV;
          end
        end
        S_ADV: begin
          if (left_r == '0) begin
            cur_r <= rtgt_r;
          end else begin
            left_r <= left_r - 1'b1;
            cur_r  <= (left_r != 12'd1) ? cur_sum[DLY_W-1:0] : rtgt_r;
          end
          state_r <= S_ADDR;
        end
        S_ADDR: begin
          i1_r    <= i1;
          i2_r    <= (i1 == LAST) ? '0 : i1 + 1'b1;
          frac_r  <= rp[15:0];
          state_r <= S_RD1;
        end
        S_RD1: state_r <= S_RD2;
        S_RD2: begin
          m1_r    <= m_rd;
          state_r <= S_INTERP;
        end
        S_INTERP: state_r <= S_DLY;
        S_DLY: begin
          dly_r   <= m1_r + SB'(prod_r >>> 16);
          state_r <= S_DRY;
        end
        S_DRY: state_r <= S_WET;
        S_WET: begin
          acc_r   <= ACC_W'(prod_r);
          state_r <= S_FB;
        end
        S_FB: begin
          acc_r   <= acc_r + ACC_W'(prod_r);
          state_r <= S_WR;
        end
        S_WR: begin
          out_r     <= sat_f(y_rnd);
          wp_r      <= (wp_r == LAST) ? '0 : wp_r + 1'b1;
          wrapped_r <= wrapped_r | (wp_r == LAST);
          state_r   <= S_DONE;
        end
        S_DONE: begin
          // hold until the output register is free
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // output data register loads with the result in the done state
  always_ff @(posedge clk) begin
    if ((state_r == S_DONE) && (!out_valid_r || out_ready)) begin
      out_sample_out <= out_r;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

FILE: design/fdl_check.sv
`default_nettype none
module fdl_check #(
  parameter int unsigned SB = fdl_pkg::SAMPLE_BITS_DEF
) (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic signed [SB-1:0] out_sample_out,
  input logic                 pready
);

  // a taken request keeps the block busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("in_ready stayed high after a request");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_sample_out)))
    else $error("stalled result changed or dropped");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && in_ready))
    else $error("reset did not clear the channels");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready dropped");

endmodule

bind feedback_delay_line fdl_check #(.SB(SAMPLE_BITS)) u_fdl_check (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_sample_out (out_sample_out),
  .pready         (pready)
);
`default_nettype wire

FILE: tb/sv/feedback_delay_line_tb.sv
`default_nettype none
module feedback_delay_line_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fdl_pkg::*;

  localparam int unsigned DEPTH = DEPTH_DEF;
  localparam int unsigned SBITS = SAMPLE_BITS_DEF;
  localparam int unsigned IDLE_LIMIT = 20000;
  localparam int unsigned SETTLE_CYCLES = 300;
  localparam longint SAT_HI = (longint'(1) <<< (SBITS - 1)) - 1;
  localparam longint SAT_LO = -SAT_HI - 1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [SBITS-1:0] in_sample_in = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [SBITS-1:0] out_sample_out;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  feedback_delay_line DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_sample_in(in_sample_in),
    .out_valid(out_valid), .out_ready(out_ready), .out_sample_out(out_sample_out),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Echo state mirrored in the testbench: delay memory, pointer, ramp.
  logic signed [SBITS-1:0] echo_mem [DEPTH];
  int unsigned      wr_ptr;
  longint unsigned  delay_now;
  longint unsigned  delay_goal;
  longint           ramp_inc;
  int unsigned      ramp_left;
  logic [RATE_W-1:0] rate_r;
  logic [MS_W-1:0]   ms_r;
  logic [FB_W-1:0]   fb_r;
  logic [MIX_W-1:0]  mix_r;

  logic signed [SBITS-1:0] pending_samples[$];
  logic signed [SBITS-1:0] mixed_expected[$];
  bit failed = 1'b0;

  function automatic longint clip(input longint v);
    if (v > SAT_HI) return SAT_HI;
    if (v < SAT_LO) return SAT_LO;
    return v;
  endfunction

  // Move the smoothed delay one sample toward rate*ms/1000.
  function automatic void step_ramp();
    longint unsigned goal;
    int unsigned len;
    goal = (longint'(rate_r) * longint'(ms_r) * 65536) / 1000;
    len = rate_r / RAMP_DIV;
    if (goal > longint'(DEPTH - 1) * 65536) goal = longint'(DEPTH - 1) * 65536;
    if (len > RAMP_MAX) len = RAMP_MAX;
    if (goal != delay_goal) begin
      delay_goal = goal;
      if (len == 0) begin
        delay_now = goal;
        ramp_left = 0;
        ramp_inc = 0;
      end else begin
        ramp_left = len;
        ramp_inc = (longint'(goal) - longint'(delay_now)) / longint'(len);
      end
    end
    if (ramp_left == 0) begin
      delay_now = delay_goal;
    end else begin
      ramp_left--;
      if (ramp_left > 0) delay_now = longint'(delay_now) + ramp_inc;
      else delay_now = delay_goal;
    end
  endfunction

  // Interpolated tap, dry/wet mix and feedback writeback for one sample.
  function automatic logic signed [SBITS-1:0] echo_mix(input logic signed [SBITS-1:0] x);
    longint unsigned rp;
    int unsigned i1, i2, mix;
    longint frac, m1, m2, tap, y, w;
    step_ramp();
    rp = longint'(wr_ptr) * 65536;
    if (rp < delay_now) rp += longint'(DEPTH) * 65536;
    rp -= delay_now;
    i1 = rp >> 16;
    if (i1 >= DEPTH) i1 = 0;
    frac = rp & 64'hFFFF;
    i2 = i1 + 1;
    if (i2 >= DEPTH) i2 = 0;
    m1 = echo_mem[i1];
    m2 = echo_mem[i2];
    tap = m1 + ((frac * (m2 - m1)) >>> 16);
    mix = (mix_r > MIX_ONE) ? MIX_ONE : mix_r;
    y = longint'(x) * longint'(MIX_ONE - mix) + tap * longint'(mix);
    y = clip((y + longint'(RND_HALF)) >>> 15);
    w = longint'(x) + ((tap * longint'(fb_r) + longint'(RND_HALF)) >>> 15);
    echo_mem[wr_ptr] = clip(w);
    wr_ptr = (wr_ptr + 1 >= DEPTH) ? 0 : wr_ptr + 1;
    return y;
  endfunction

  // Sender side: bursts of random length, random gaps between them.
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  bit in_took = 1'b0;

  always @(negedge clk) begin
    if (!in_valid || in_took) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_samples.size() > 0 && rst_n) begin
        in_valid <= 1'b1;
        in_sample_in <= pending_samples.pop_front();
        if (burst_left > 1) begin
          burst_left <= burst_left - 1;
        end else begin
          // Leave some stretches with no gaps at all.
          burst_left <= $urandom_range(1, 12);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver side: stall on its own pattern, switching mode every so often.
  int unsigned stall_mode = 0;
  int unsigned mode_cnt = 0;
  logic [15:0] stall_pat = 16'hA5C3;

  always @(negedge clk) begin
    if (mode_cnt == 0) begin
      mode_cnt <= $urandom_range(50, 400);
      stall_mode <= $urandom_range(0, 3);
    end else begin
      mode_cnt <= mode_cnt - 1;
    end
    stall_pat <= {stall_pat[14:0], stall_pat[15] ^ stall_pat[13] ^ stall_pat[12] ^ stall_pat[10]};
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= stall_pat[0];
      2: out_ready <= stall_pat[0] | stall_pat[3];
      default: out_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // Predict on each accepted request; check each accepted result in order.
  always @(posedge clk) begin
    in_took <= in_valid && in_ready;
    if (rst_n && in_valid && in_ready)
      mixed_expected.push_back(echo_mix(in_sample_in));
    if (rst_n && out_valid && out_ready) begin
      if (mixed_expected.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0d", $time, out_sample_out);
        failed = 1'b1;
      end else begin
        logic signed [SBITS-1:0] want;
        want = mixed_expected.pop_front();
        if (want !== out_sample_out) begin
          $display("%0t: sample_out mismatch, expected %0d, actual %0d",
                   $time, want, out_sample_out);
          failed = 1'b1;
        end
      end
    end
  end

  // Abort when nothing moves for too long.
  int unsigned idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic reg_write(input reg_idx_t idx, input logic [DATA_W-1:0] val);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_RATE: rate_r = val[RATE_W-1:0];
      REG_MS:   ms_r = val[MS_W-1:0];
      REG_FB:   fb_r = val[FB_W-1:0];
      REG_MIX:  mix_r = val[MIX_W-1:0];
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_all(input int unsigned rate, input int unsigned ms,
                         input int unsigned fb, input int unsigned mix);
    reg_write(REG_RATE, rate);
    reg_write(REG_MS, ms);
    reg_write(REG_FB, fb);
    reg_write(REG_MIX, mix);
  endtask

  // Hold until every request went through and every result came back.
  task automatic drain();
    wait (pending_samples.size() == 0 && !in_valid && mixed_expected.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [SBITS-1:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return SAT_HI - $urandom_range(0, 255);
      1: return SAT_LO + $urandom_range(0, 255);
      2: return $urandom_range(0, 2047) - 1024;
      default: return $urandom();
    endcase
  endfunction

  task automatic load(input int unsigned n);
    repeat (n) pending_samples.push_back(rand_sample());
  endtask

  initial begin
    for (int i = 0; i < DEPTH; i++) echo_mem[i] = '0;
    wr_ptr = 0;
    delay_now = 0;
    delay_goal = 0;
    ramp_inc = 0;
    ramp_left = 0;
    rate_r = RATE_RST;
    ms_r = MS_RST;
    fb_r = FB_RST;
    mix_r = MIX_RST;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: sample extremes and bit patterns at the reset settings.
    pending_samples = '{24'sh7FFFFF, 24'sh800000, 24'sh000000, 24'shFFFFFF,
                        24'sh555555, 24'shAAAAAA, 24'sh000001, 24'sh7FFFFF,
                        24'sh800000, 24'sh123456};
    drain();

    // Rate below 20: no ramp, the delay jumps to 20 samples; full wet, high feedback (31130).
    set_all(10, 2000, 31130, MIX_ONE);
    pending_samples = '{24'sh7FFFFF, 24'sh7FFFFF, 24'sh800000};
    load(60);
    drain();

    // Zero delay reads the oldest cell; mix above one and feedback at 15-bit max.
    set_all(0, 2000, 32767, 65535);
    load(40);
    drain();

    // Fractional delay (0.06 samples), one-item ramp, all dry, no feedback.
    set_all(20, 3, 0, 0);
    load(40);
    drain();

    // Ramp from a short delay up toward 8 samples over 400 items.
    set_all(8000, 1, 20000, 30000);
    load(90);
    drain();

    // Delay beyond memory clamps; ramp length saturates at its maximum.
    set_all(131071, 2047, 16384, 16384);
    load(40);
    drain();

    // Short ramp: 15 samples over 5 items, then the target stays put.
    set_all(100, 150, 29000, 24000);
    load(60);
    drain();

    // Random settings, mostly short delays so echoes of written samples show up.
    repeat (6) begin
      if ($urandom_range(0, 3) == 0)
        set_all($urandom_range(0, 131071), $urandom_range(0, 2047),
                $urandom_range(0, 32767), $urandom_range(0, 65535));
      else
        set_all($urandom_range(0, 400), $urandom_range(1, 60),
                $urandom_range(0, 31130), $urandom_range(0, MIX_ONE));
      load($urandom_range(40, 60));
      drain();
    end

    if (!failed)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
`default_nettype wire
